/* hw/rtl/rttt_pkg.sv */
// Package for the request tag tracker timeout unit: opcodes, result kinds,
// and the command/result structs. No dependencies.
package rttt_pkg;
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_RESP  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;
	localparam logic [1:0] REQ_FLUSH = 2'd3;

	localparam logic [2:0] K_ALLOC   = 3'd0;
	localparam logic [2:0] K_REFUSE  = 3'd1;
	localparam logic [2:0] K_PASS    = 3'd2;
	localparam logic [2:0] K_DROP    = 3'd3;
	localparam logic [2:0] K_TIMEOUT = 3'd4;
	localparam logic [2:0] K_FLUSH   = 3'd5;

	localparam logic [15:0] TIMEOUT_RST = 16'd35;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] tag;
		logic        link_up;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] tag_res;
		logic [5:0]  slot;
		logic        last;
	} res_t;
endpackage

/* hw/rtl/request_tag_tracker_timeout_unit.sv */
// Channel   | Signals                      | Accepted when
// in        | push/full, req_type,tag,link_up | push && !full
// out       | empty/pop, kind,tag_res,slot,last | pop && !empty
// cfg       | cfg_we, cfg_wdata            | cfg_we
// An item scans the table by reading each slot through the single read port of
// the slot RAM and then deciding on it; an allocate or response may stop at a
// match, and a refused allocate with the link down skips the scan. A two-entry
// command queue lets input arrive while the engine works. Output stalls hold a
// tick or flush scan and the final result. Reset clears control state; the table reads as zero.
// Top level; depends on rttt_pkg, rttt_cmd_fifo, rttt_engine, rttt_ram.
module request_tag_tracker_timeout_unit
	import rttt_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [15:0] tag,
	input  logic        link_up,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [15:0] tag_res,
	output logic [5:0]  slot,
	output logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	logic [15:0] timeout_q;
	cmd_t        cin, cq;
	logic        q_empty, q_pop, res_v;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	assign cin = '{req_type: req_type, tag: tag, link_up: link_up};

	rttt_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(cin), .full(full),
		.pop(q_pop), .rdata(cq), .empty(q_empty)
	);

	rttt_engine #(.SLOTS(SLOTS)) u_eng (
		.clk(clk), .arst_n(arst_n), .timeout_secs(timeout_q),
		.cmd_valid(!q_empty), .cmd(cq), .cmd_pop(q_pop),
		.res_valid(res_v), .res(res), .res_pop(pop)
	);

	assign empty   = !res_v;
	assign kind    = res.kind;
	assign tag_res = res.tag_res;
	assign slot    = res.slot;
	assign last    = res.last;

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> kind <= K_FLUSH) else $error("bad kind");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(tag_res))) else $error("result lost");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == K_ALLOC || kind == K_REFUSE || kind == K_PASS
		 || kind == K_DROP)) |-> last) else $error("single result not last");
endmodule

/* hw/rtl/rttt_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rttt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hw/rtl/rttt_cmd_fifo.sv */
// Front part: command queue between the input port and the table engine.
// Depends on rttt_pkg.
module rttt_cmd_fifo
	import rttt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);
	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && !empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

/* hw/rtl/rttt_engine.sv */
// Back part: scans the slot table one slot at a time and emits results; it takes a new command only when idle.
// Depends on rttt_pkg and rttt_ram.
module rttt_engine
	import rttt_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] timeout_secs,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        res_valid,
	output res_t        res,
	input  logic        res_pop
);
	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LASTIDX = IW'(SLOTS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]    state_q;
	cmd_t          cmd_q;
	logic [IW-1:0] idx_q;       // address being read
	logic [IW-1:0] eidx_q;      // slot whose data is valid on rdata
	logic          pend_q;      // read data valid
	logic          fnd_q;       // found a choice
	logic          stale_hit_q; // allocate: stale same-tag match; response: matched slot was stale
	logic [IW-1:0] sel_q;
	logic [31:0]   now_q;
	logic [SLOTS-1:0] act_q;
	logic [SLOTS-1:0] vld_q;    // entry written since reset/flush
	logic          out_v_q;
	res_t          out_q;
	logic          prev_v_q;    // one pending tick/flush report held back
	res_t          prev_q;
	logic          scan_end_q;

	// table memory: tag, start, stale
	logic          we;
	logic [IW-1:0] waddr;
	logic [63:0]   wdata, rdata_raw, rd;
	logic [IW-1:0] raddr;

	rttt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata_raw)
	);

	logic          r_vld;
	assign r_vld = vld_q[eidx_q];
	assign rd    = r_vld ? rdata_raw : 64'd0;

	logic [15:0] r_tag, r_stale;
	logic [31:0] r_start;
	assign r_tag   = rd[63:48];
	assign r_start = rd[47:16];
	assign r_stale = rd[15:0];

	logic [31:0] age;
	assign age = now_q - r_start;

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign res_valid = out_v_q;
	assign res       = out_q;

	logic out_free;
	assign out_free = !out_v_q || res_pop;

	// scan decisions on the slot at eidx_q
	logic hit_to, hit_fl, is_rep, rep_hit, out_ld;
	assign hit_to  = act_q[eidx_q] && (age >= {16'd0, timeout_secs});
	assign hit_fl  = act_q[eidx_q];
	assign is_rep  = cmd_q.req_type inside {REQ_TICK, REQ_FLUSH};
	assign rep_hit = (cmd_q.req_type == REQ_TICK) ? hit_to : hit_fl;

	// output register load
	always_comb begin
		case (state_q)
			ST_SCAN: out_ld = is_rep && pend_q && out_free && prev_v_q && rep_hit;
			ST_DONE: out_ld = is_rep && out_free && prev_v_q;
			ST_EMIT: out_ld = out_free;
			default: out_ld = 1'b0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = eidx_q;
		wdata = rd;
		// hold the address while the read data is still needed
		if (state_q == ST_EVAL) begin
			raddr = sel_q;
		end else if (pend_q) begin
			raddr = eidx_q;
		end else begin
			raddr = idx_q;
		end
		if (state_q == ST_SCAN && pend_q && out_free
		    && cmd_q.req_type == REQ_TICK && hit_to) begin
			we = 1'b1;
			wdata[15:0] = (r_stale == 16'hFFFF) ? r_stale : r_stale + 16'd1;
		end
		if (state_q == ST_DONE && fnd_q) begin
			waddr = sel_q;
			we    = 1'b1;
			if (cmd_q.req_type == REQ_ALLOC) begin
				wdata = {cmd_q.tag, now_q, r_stale};
			end else begin
				wdata = {r_tag, r_start, r_stale - 16'd1};
				we    = (r_stale != 16'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			eidx_q      <= '0;
			pend_q      <= 1'b0;
			fnd_q       <= 1'b0;
			stale_hit_q <= 1'b0;
			sel_q       <= '0;
			now_q       <= 32'd0;
			act_q       <= '0;
			vld_q       <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
			prev_v_q    <= 1'b0;
			prev_q      <= '0;
			scan_end_q  <= 1'b0;
		end else begin
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (res_pop) begin
				out_v_q <= 1'b0;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q       <= '0;
						pend_q      <= 1'b0;
						fnd_q       <= 1'b0;
						stale_hit_q <= 1'b0;
						scan_end_q  <= 1'b0;
						if (cmd.req_type == REQ_TICK) begin
							now_q <= now_q + 32'd1;
						end
						if (cmd.req_type == REQ_ALLOC && !cmd.link_up) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// read issues idx_q; data for eidx_q appears the next cycle
					if (!pend_q) begin
						eidx_q <= idx_q;
						pend_q <= 1'b1;
						if (idx_q != LASTIDX) begin
							idx_q <= idx_q + IW'(1);
						end else begin
							scan_end_q <= 1'b1;
						end
					end else if (cmd_q.req_type == REQ_ALLOC
					             || cmd_q.req_type == REQ_RESP) begin
						if (cmd_q.req_type == REQ_ALLOC) begin
							if (r_stale != 16'd0) begin
								if (r_tag == cmd_q.tag) begin
									fnd_q       <= 1'b1;
									stale_hit_q <= 1'b1;
									sel_q       <= eidx_q;
								end
							end else if (!fnd_q && !act_q[eidx_q]) begin
								fnd_q <= 1'b1;
								sel_q <= eidx_q;
							end
						end else if (!fnd_q && r_tag == cmd_q.tag) begin
							fnd_q <= 1'b1;
							sel_q <= eidx_q;
						end
						if (scan_end_q || (cmd_q.req_type == REQ_ALLOC
						    && r_stale != 16'd0 && r_tag == cmd_q.tag)
						    || (cmd_q.req_type == REQ_RESP && r_tag == cmd_q.tag)) begin
							state_q <= ST_EVAL;
						end else begin
							pend_q <= 1'b0;
						end
						if (stale_hit_q) begin
							state_q <= ST_EVAL;
						end
					end else if (out_free) begin
						// tick or flush: hold the newest report back so the final one
						// can be marked last; the one before it goes out now
						if (rep_hit) begin
							if (prev_v_q) begin
								out_q <= prev_q;
							end
							prev_v_q      <= 1'b1;
							prev_q.kind   <= (cmd_q.req_type == REQ_TICK) ? K_TIMEOUT : K_FLUSH;
							prev_q.tag_res <= r_tag;
							prev_q.slot   <= 6'(eidx_q);
							prev_q.last   <= 1'b0;
							if (cmd_q.req_type == REQ_TICK) begin
								act_q[eidx_q] <= 1'b0;
							end
						end
						if (scan_end_q) begin
							state_q <= ST_DONE;
						end else begin
							pend_q <= 1'b0;
						end
					end
				end
				ST_EVAL: begin
					// re-read the selected slot
					eidx_q  <= sel_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd_q.req_type == REQ_ALLOC || cmd_q.req_type == REQ_RESP) begin
						state_q <= ST_EMIT;
						if (cmd_q.req_type == REQ_ALLOC && fnd_q) begin
							act_q[sel_q] <= 1'b1;
						end
						if (cmd_q.req_type == REQ_RESP && fnd_q && r_stale == 16'd0) begin
							act_q[sel_q] <= 1'b0;
						end
						if (cmd_q.req_type == REQ_RESP && fnd_q) begin
							stale_hit_q <= (r_stale != 16'd0);
						end
					end else if (out_free) begin
						if (prev_v_q) begin
							out_q    <= '{kind: prev_q.kind, tag_res: prev_q.tag_res,
							             slot: prev_q.slot, last: 1'b1};
							prev_v_q <= 1'b0;
						end
						if (cmd_q.req_type == REQ_FLUSH) begin
							act_q <= '0;
							vld_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q.tag_res <= cmd_q.tag;
						out_q.last    <= 1'b1;
						out_q.slot    <= fnd_q ? 6'(sel_q) : 6'd0;
						if (cmd_q.req_type == REQ_ALLOC) begin
							out_q.kind <= fnd_q ? K_ALLOC : K_REFUSE;
						end else begin
							out_q.kind <= (fnd_q && !stale_hit_q) ? K_PASS : K_DROP;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* tb/request_tag_tracker_timeout_unit_tb.sv */
// Testbench for request_tag_tracker_timeout_unit: drives allocate, response,
// tick and flush transactions and checks results against a tag table model.
// Depends on rttt_pkg and the unit RTL.
`timescale 1ns / 100ps

module request_tag_tracker_timeout_unit_tb;
	import rttt_pkg::*;

	class tag_table_sb;
		logic [15:0] tags[64];
		bit          act[64];
		logic [31:0] start_t[64];
		logic [15:0] stale[64];
		logic [31:0] now;
		logic [15:0] timeout;
		res_t        pending[$];
		int          errors;

		function new();
			errors = 0;
			now = 0;
			timeout = TIMEOUT_RST;
			wipe();
		endfunction

		function void wipe();
			for (int i = 0; i < 64; i++) begin
				tags[i] = 0;
				act[i] = 0;
				start_t[i] = 0;
				stale[i] = 0;
			end
		endfunction

		function void add(logic [2:0] k, logic [15:0] t, int s);
			res_t r;
			r.kind = k;
			r.tag_res = t;
			r.slot = s[5:0];
			r.last = 0;
			pending.push_back(r);
		endfunction

		// predict the results of one accepted transaction
		function void note_cmd(logic [1:0] rt, logic [15:0] t, logic lk);
			int x;
			int n0;
			x = -1;
			n0 = pending.size();
			case (rt)
				REQ_ALLOC: begin
					if (lk) begin
						for (int i = 0; i < 64; i++) begin
							if (stale[i] != 0) begin
								if (tags[i] == t) begin
									x = i;
									break;
								end
							end else if (x < 0 && !act[i]) begin
								x = i;
							end
						end
					end
					if (x < 0) add(K_REFUSE, t, 0);
					else begin
						tags[x] = t;
						start_t[x] = now;
						act[x] = 1;
						add(K_ALLOC, t, x);
					end
				end
				REQ_RESP: begin
					for (int i = 0; i < 64; i++)
						if (tags[i] == t) begin
							x = i;
							break;
						end
					if (x < 0) add(K_DROP, t, 0);
					else if (stale[x] != 0) begin
						stale[x]--;
						add(K_DROP, t, x);
					end else begin
						act[x] = 0;
						add(K_PASS, t, x);
					end
				end
				REQ_TICK: begin
					now++;
					for (int i = 0; i < 64; i++)
						if (act[i] && (now - start_t[i]) >= {16'd0, timeout}) begin
							add(K_TIMEOUT, tags[i], i);
							act[i] = 0;
							if (stale[i] != 16'hFFFF) stale[i]++;
						end
				end
				default: begin
					for (int i = 0; i < 64; i++)
						if (act[i]) add(K_FLUSH, tags[i], i);
					wipe();
				end
			endcase
			if (pending.size() > n0) pending[pending.size() - 1].last = 1;
		endfunction

		function void check_res(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: kind %0d tag %h", got.kind, got.tag_res);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.kind !== e.kind) begin
				$error("kind expected %0d got %0d", e.kind, got.kind);
				errors++;
			end
			if (got.tag_res !== e.tag_res) begin
				$error("tag_res expected %h got %h", e.tag_res, got.tag_res);
				errors++;
			end
			if (got.slot !== e.slot) begin
				$error("slot expected %0d got %0d", e.slot, got.slot);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last expected %0d got %0d", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	logic [1:0]  req_type = REQ_ALLOC;
	logic [15:0] tag = 0;
	logic        link_up = 0;
	logic        empty;
	logic        pop = 0;
	logic [2:0]  kind;
	logic [15:0] tag_res;
	logic [5:0]  slot;
	logic        last;
	logic        cfg_we = 0;
	logic [15:0] cfg_wdata = 0;

	tag_table_sb sb = new();
	bit          drain_quiet = 0;
	logic [15:0] tag_pool[8];

	request_tag_tracker_timeout_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .tag(tag), .link_up(link_up),
		.empty(empty), .pop(pop), .kind(kind), .tag_res(tag_res),
		.slot(slot), .last(last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 150);
	endfunction

	// result side: random pop stalls, check at the accepting edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_res('{kind, tag_res, slot, last});
	end

	initial begin
		int g;
		@(posedge clk iff arst_n);
		forever begin
			g = drain_quiet ? 0 : pick_gap();
			if (g > 0) begin
				pop <= 0;
				repeat (g) @(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
		end
	end

	task automatic send(logic [1:0] rt, logic [15:0] t, logic lk);
		int g;
		g = pick_gap();
		if (g > 0) begin
			push <= 0;
			repeat (g) @(posedge clk);
		end
		push <= 1;
		req_type <= rt;
		tag <= t;
		link_up <= lk;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_cmd(rt, t, lk);
	endtask

	// queued transactions with no results may still be in flight
	task automatic settle();
		push <= 0;
		drain_quiet = 1;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		drain_quiet = 0;
	endtask

	task automatic set_timeout(logic [15:0] v);
		settle();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.timeout = v;
	endtask

	task automatic random_phase(int count);
		int r;
		logic [15:0] t;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : tag_pool[$urandom_range(0, 7)];
			if (r < 40) send(REQ_ALLOC, t, $urandom_range(0, 15) != 0);
			else if (r < 70) send(REQ_RESP, t, 1'($urandom));
			else if (r < 97) send(REQ_TICK, 16'($urandom), 1'($urandom));
			else send(REQ_FLUSH, 16'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, every request type, stale reuse, refusals
		send(REQ_ALLOC, 16'h0000, 1);
		send(REQ_ALLOC, 16'hFFFF, 1);
		send(REQ_ALLOC, 16'h1234, 0);
		send(REQ_RESP, 16'hFFFF, 1);
		send(REQ_RESP, 16'hBEEF, 0);
		send(REQ_TICK, 16'hFFFF, 1);
		send(REQ_FLUSH, 16'h0000, 0);
		send(REQ_FLUSH, 16'hAAAA, 1);
		set_timeout(16'd1);
		send(REQ_ALLOC, 16'h5555, 1);
		send(REQ_ALLOC, 16'hAAAA, 1);
		send(REQ_TICK, 16'h0, 0);
		send(REQ_ALLOC, 16'h5555, 1);
		send(REQ_RESP, 16'h5555, 1);
		send(REQ_RESP, 16'h5555, 1);
		send(REQ_RESP, 16'hAAAA, 1);
		set_timeout(16'd0);
		send(REQ_ALLOC, 16'h0F0F, 1);
		send(REQ_TICK, 16'h0, 1);
		send(REQ_TICK, 16'h0, 1);
		send(REQ_FLUSH, 16'h0, 1);
		// fill the table until refusal
		for (int i = 0; i < 66; i++) send(REQ_ALLOC, 16'(i * 97), 1);
		send(REQ_FLUSH, 16'h0, 1);
		set_timeout(16'hFFFF);
		for (int i = 0; i < 8; i++) tag_pool[i] = 16'($urandom);
		random_phase(60);
		set_timeout(16'd3);
		random_phase(120);
		set_timeout(16'd1);
		random_phase(80);
		set_timeout(16'($urandom_range(2, 8)));
		random_phase(114);
		settle();
		if (sb.errors == 0)
			$display("PASS request_tag_tracker_timeout_unit");
		else
			$display("FAIL request_tag_tracker_timeout_unit");
		$finish;
	end

	initial begin
		#200ms;
		$display("FAIL request_tag_tracker_timeout_unit");
		$finish;
	end
endmodule
